@@ src/swmm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window min/max package
// Beat payload types, register width and reset value, and the per-cell
// running min/max record.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int SampleW = 32;
  localparam int WinLenW = 7;
  localparam logic [WinLenW-1:0] WinLenReset = 7'd1;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      restart;
  } swmm_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] window_min;
    logic signed [SampleW-1:0] window_max;
  } swmm_out_t;

  // Running min/max over a suffix of the stream
  typedef struct packed {
    logic signed [SampleW-1:0] lo;
    logic signed [SampleW-1:0] hi;
  } swmm_acc_t;

endpackage

@@ src/swmm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window min/max cell
// Folds the broadcast sample into the neighbor's running min/max and keeps
// the result; cell k covers the newest k+1 samples.
// ----------------------------------------------------------------------------
module swmm_cell (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [swmm_pkg::SampleW-1:0] sample_i,
  input  swmm_pkg::swmm_acc_t                prev_i,
  output swmm_pkg::swmm_acc_t                acc_d_o,
  output swmm_pkg::swmm_acc_t                acc_q_o
);
  import swmm_pkg::*;

  swmm_acc_t acc_d, acc_q;

  always_comb begin
    acc_d.lo = (sample_i < prev_i.lo) ? sample_i : prev_i.lo;
    acc_d.hi = (sample_i > prev_i.hi) ? sample_i : prev_i.hi;
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_d_o = acc_d;
  assign acc_q_o = acc_q;

endmodule

@@ src/swmm_skid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window min/max output buffer
// Output register plus one skid entry; stall upstream only when the skid
// entry is occupied.
// ----------------------------------------------------------------------------
module swmm_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  swmm_pkg::swmm_out_t data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output swmm_pkg::swmm_out_t out_data_o
);
  import swmm_pkg::*;

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  swmm_out_t main_q, main_d;
  swmm_out_t skid_q, skid_d;
  logic      take;

  assign take = main_valid_q & ~out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (take) begin
      main_valid_d = 1'b0;
    end
    if (take && skid_valid_q) begin
      main_d       = skid_q;
      main_valid_d = 1'b1;
      skid_valid_d = 1'b0;
    end
    // push only arrives with the skid entry empty
    if (push_i) begin
      if (!main_valid_q || take) begin
        main_d       = data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

@@ src/sliding_window_min_max_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window min/max, top level
// Each result beat is registered in the output buffer from its sample beat.
// Throughput: one sample beat per cycle unless stalled; all cells update together.
// Input stalls only while both output register and skid entry hold results.
// Reset clears fill count, output valids and window_length (to 1); the cell
// contents are not cleared, since no result reads a cell beyond the fill count.
// ----------------------------------------------------------------------------
module sliding_window_min_max_top #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // sample channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  swmm_pkg::swmm_in_t               in_data_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output swmm_pkg::swmm_out_t              out_data_o,
  // window_length register write
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [swmm_pkg::WinLenW-1:0]     cfg_data_i
);
  import swmm_pkg::*;

  localparam int CntW = $clog2(WINDOW_MAX + 1);
  localparam int LenW = (CntW > WinLenW) ? CntW : WinLenW;
  localparam int IdxW = $clog2(WINDOW_MAX);

  // Cell k holds min/max of the newest k+1 samples. Each beat the new sample
  // is broadcast to every cell, which folds it into its left neighbor's
  // record and takes the result; cell 0 folds the sample into itself.
  swmm_acc_t acc_d [WINDOW_MAX];
  swmm_acc_t acc_q [WINDOW_MAX];

  logic [WinLenW-1:0] win_len_q;
  logic [CntW-1:0]    fill_q, fill_d, fill_base;
  logic [LenW-1:0]    len_ext, act_len;
  logic [IdxW-1:0]    tap_idx;
  logic               accept, has_result, buf_full;
  swmm_acc_t          seed;
  swmm_out_t          result;

  assign accept      = in_valid_i & ~in_stall_o;
  assign in_stall_o  = buf_full;
  assign cfg_ready_o = 1'b1;

  assign seed.lo = in_data_i.sample;
  assign seed.hi = in_data_i.sample;

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    swmm_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (accept),
      .sample_i (in_data_i.sample),
      .prev_i   ((k == 0) ? seed : acc_q[(k == 0) ? 0 : k - 1]),
      .acc_d_o  (acc_d[k]),
      .acc_q_o  (acc_q[k])
    );
  end

  // Zero length acts as 1, oversized length as WINDOW_MAX
  always_comb begin
    len_ext = LenW'(win_len_q);
    if (len_ext == '0) begin
      act_len = LenW'(1);
    end else if (len_ext > LenW'(WINDOW_MAX)) begin
      act_len = LenW'(WINDOW_MAX);
    end else begin
      act_len = len_ext;
    end
  end

  assign tap_idx = IdxW'(act_len - LenW'(1));

  // Restart clears the count before the sample is counted; saturates
  always_comb begin
    fill_base = in_data_i.restart ? '0 : fill_q;
    fill_d    = (fill_base < CntW'(WINDOW_MAX)) ? fill_base + CntW'(1) : fill_base;
  end

  assign has_result = (LenW'(fill_d) >= act_len);

  assign result.window_min = acc_d[tap_idx].lo;
  assign result.window_max = acc_d[tap_idx].hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      win_len_q <= WinLenReset;
    end else begin
      if (accept) begin
        fill_q <= fill_d;
      end
      if (cfg_valid_i) begin
        win_len_q <= cfg_data_i;
      end
    end
  end

  swmm_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept & has_result),
    .data_i      (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
